>>> sv/sgtp_pkg.sv
// ----------------------------------------------------------------------------
// sgtp_pkg
// Shared types, constants and helpers of the spiral grid tile placer.
// ----------------------------------------------------------------------------
package sgtp_pkg;

  // Fixed point and field widths.
  localparam int FRAC_BITS = 4;
  localparam int MAX_TILES = 64;
  localparam int CNT_W     = 7;
  localparam int IDX_W     = 6;
  localparam int SCR_W     = 13;
  localparam int ORG_W     = 16;
  localparam int GAP_W     = 8;
  localparam int LEN_W     = SCR_W + FRAC_BITS;  // screen length in fixed point
  localparam int POS_W     = 21;
  localparam int SIZE_W    = 18;
  localparam int SIDE_W    = 4;
  localparam int COORD_W   = 6;                  // signed spiral coordinate
  localparam int SEG_W     = 5;

  // The single-tile rectangle covers 4/5 of the screen.
  localparam int SINGLE_NUM_SH = 2;
  localparam logic [SIDE_W-1:0] SINGLE_DEN = 4'd5;

  // Divider: dividend wide enough for four times the screen length.
  localparam int DIVD_W    = LEN_W + SINGLE_NUM_SH;
  localparam int DIV_CNT_W = 5;

  // Command queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Register map and reset values.
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam logic [SCR_W-1:0] RST_SCREEN_W = 13'd1920;
  localparam logic [SCR_W-1:0] RST_SCREEN_H = 13'd1080;

  typedef enum logic [2:0] {
    REG_SCREEN_W = 3'd0,
    REG_SCREEN_H = 3'd1,
    REG_ORIGIN_X = 3'd2,
    REG_ORIGIN_Y = 3'd3,
    REG_GAP      = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [SCR_W-1:0] screen_width;
    logic [SCR_W-1:0] screen_height;
    logic [ORG_W-1:0] origin_x;
    logic [ORG_W-1:0] origin_y;
    logic [GAP_W-1:0] gap;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_EMPTY  = 2'd0,
    KIND_SINGLE = 2'd1,
    KIND_GRID   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CNT_W-1:0]  count;
    logic [SIDE_W-1:0] side;
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [SIDE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic                     last;
    logic                     tile_valid;
    logic [SIDE_W-1:0]        grid_side;
    logic signed [SIZE_W-1:0] size_h;
    logic signed [SIZE_W-1:0] size_w;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_x;
    logic [IDX_W-1:0]         tile_index;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START_W,
    ST_WAIT_W,
    ST_START_H,
    ST_WAIT_H,
    ST_CLAMP,
    ST_BASE,
    ST_WALK,
    ST_EMIT_ONE
  } back_state_t;

  typedef enum logic [1:0] {
    DIR_RIGHT,
    DIR_DOWN,
    DIR_LEFT,
    DIR_UP
  } dir_t;

  // Smallest g with g*g >= n, for n from 2 up to MAX_TILES.
  function automatic logic [SIDE_W-1:0] ceil_sqrt(input logic [CNT_W-1:0] n);
    logic [SIDE_W-1:0] g;
    priority if (n <= 7'd4)  g = 4'd2;
    else if (n <= 7'd9)      g = 4'd3;
    else if (n <= 7'd16)     g = 4'd4;
    else if (n <= 7'd25)     g = 4'd5;
    else if (n <= 7'd36)     g = 4'd6;
    else if (n <= 7'd49)     g = 4'd7;
    else                     g = 4'd8;
    return g;
  endfunction

endpackage

>>> sv/sgtp_front.sv
// ----------------------------------------------------------------------------
// sgtp_front
// Accepts tile-count transactions and turns them into queued commands.
// ----------------------------------------------------------------------------
module sgtp_front (
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [6:0] tile_count, [7] zero fill
  input  logic                 q_full,
  output logic                 q_push,
  output sgtp_pkg::cmd_t       q_cmd
);

  logic [sgtp_pkg::CNT_W-1:0] count_raw;
  logic [sgtp_pkg::CNT_W-1:0] count_sat;

  assign count_raw = in_tdata[sgtp_pkg::CNT_W-1:0];
  // Requests above capacity are served as a full grid.
  assign count_sat = (count_raw > sgtp_pkg::CNT_W'(sgtp_pkg::MAX_TILES))
                   ? sgtp_pkg::CNT_W'(sgtp_pkg::MAX_TILES) : count_raw;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_cmd.count = count_sat;
    if (count_sat == '0) begin
      q_cmd.kind = sgtp_pkg::KIND_EMPTY;
      q_cmd.side = sgtp_pkg::SIDE_W'(1);
    end else if (count_sat == sgtp_pkg::CNT_W'(1)) begin
      q_cmd.kind = sgtp_pkg::KIND_SINGLE;
      q_cmd.side = sgtp_pkg::SIDE_W'(1);
    end else begin
      q_cmd.kind = sgtp_pkg::KIND_GRID;
      q_cmd.side = sgtp_pkg::ceil_sqrt(count_sat);
    end
  end

endmodule

>>> sv/sgtp_cmd_fifo.sv
// ----------------------------------------------------------------------------
// sgtp_cmd_fifo
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module sgtp_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sgtp_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output sgtp_pkg::cmd_t pop_cmd,
  output logic           empty
);

  sgtp_pkg::cmd_t                mem_r [sgtp_pkg::QDEPTH];
  logic [sgtp_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [sgtp_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [sgtp_pkg::QCNT_W-1:0]   cnt_r;

  assign full    = (cnt_r == sgtp_pkg::QCNT_W'(sgtp_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_cmd = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= sgtp_pkg::QPTR_W'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= sgtp_pkg::QPTR_W'(rd_ptr_r + 1'b1);
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= sgtp_pkg::QCNT_W'(cnt_r + 1'b1);
        2'b01:   cnt_r <= sgtp_pkg::QCNT_W'(cnt_r - 1'b1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> sv/sgtp_div.sv
// ----------------------------------------------------------------------------
// sgtp_div
// Radix-2 restoring divider of a screen length by a small unsigned divisor.
// ----------------------------------------------------------------------------
module sgtp_div (
  input  logic               clk,
  input  logic               rst_n,
  input  sgtp_pkg::div_req_t req,
  output sgtp_pkg::div_rsp_t rsp
);

  logic [sgtp_pkg::DIVD_W-1:0]    quo_r, quo_nxt;
  logic [sgtp_pkg::SIDE_W-1:0]    rem_r, rem_nxt;
  logic [sgtp_pkg::SIDE_W-1:0]    dvs_r, dvs_nxt;
  logic [sgtp_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [sgtp_pkg::SIDE_W:0]      trial;
  logic [sgtp_pkg::SIDE_W:0]      diff;
  logic                           fits;

  // One quotient bit per cycle, most significant first.
  assign trial = {rem_r, quo_r[sgtp_pkg::DIVD_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      quo_nxt = {quo_r[sgtp_pkg::DIVD_W-2:0], fits};
      rem_nxt = fits ? diff[sgtp_pkg::SIDE_W-1:0] : trial[sgtp_pkg::SIDE_W-1:0];
      cnt_nxt = sgtp_pkg::DIV_CNT_W'(cnt_r + 1'b1);
      if (cnt_r == sgtp_pkg::DIV_CNT_W'(sgtp_pkg::DIVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

>>> sv/sgtp_back.sv
// ----------------------------------------------------------------------------
// sgtp_back
// Sizes the tiles, walks the square spiral and drives the result register.
// ----------------------------------------------------------------------------
module sgtp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  sgtp_pkg::cfg_t     cfg,
  input  logic               q_empty,
  input  sgtp_pkg::cmd_t     q_cmd,
  output logic               q_pop,
  output sgtp_pkg::div_req_t div_req,
  input  sgtp_pkg::div_rsp_t div_rsp,
  output logic               res_valid,
  input  logic               res_ready,
  output sgtp_pkg::res_t     res
);

  localparam int LW = sgtp_pkg::LEN_W;
  localparam int PW = sgtp_pkg::POS_W;
  localparam int ZW = sgtp_pkg::SIZE_W;
  localparam int GW = sgtp_pkg::SIDE_W;
  localparam int CW = sgtp_pkg::COORD_W;
  localparam int FB = sgtp_pkg::FRAC_BITS;

  sgtp_pkg::back_state_t   state_r, state_nxt;
  sgtp_pkg::kind_t         kind_r, kind_nxt;
  sgtp_pkg::dir_t          dir_r, dir_nxt;
  logic [sgtp_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [GW-1:0]           g_r, g_nxt;
  logic [LW-1:0]           tw_r, tw_nxt;
  logic [LW-1:0]           th_r, th_nxt;
  logic signed [PW-1:0]    base_x_r, base_x_nxt;
  logic signed [PW-1:0]    base_y_r, base_y_nxt;
  logic signed [ZW-1:0]    size_w_r, size_w_nxt;
  logic signed [ZW-1:0]    size_h_r, size_h_nxt;
  logic signed [CW-1:0]    x_r, x_nxt;
  logic signed [CW-1:0]    y_r, y_nxt;
  logic [sgtp_pkg::SEG_W-1:0] seg_r, seg_nxt;
  logic [sgtp_pkg::SEG_W-1:0] passed_r, passed_nxt;
  logic                    turn_odd_r, turn_odd_nxt;
  logic [sgtp_pkg::IDX_W-1:0] placed_r, placed_nxt;
  logic                    out_valid_r, out_valid_nxt;
  sgtp_pkg::res_t          res_r, res_nxt;

  logic                    is_grid;
  logic                    slot_ok;
  logic                    in_grid;
  logic                    is_last;
  logic [LW-1:0]           scr_w;
  logic [LW-1:0]           scr_h;
  logic [11:0]             margin;
  logic signed [PW-1:0]    org_x;
  logic signed [PW-1:0]    org_y;
  logic [LW+GW-1:0]        g_tw;
  logic [LW+GW-1:0]        g_th;
  logic [LW-1:0]           span_x;
  logic [LW-1:0]           span_y;
  logic [LW:0]             tw3;
  logic [LW-1:0]           th_lim;
  logic [LW+2:0]           x_tw;
  logic [LW+2:0]           y_th;
  logic signed [CW-1:0]    x_step;
  logic signed [CW-1:0]    y_step;
  logic [sgtp_pkg::SEG_W-1:0] passed_inc;

  assign is_grid = (kind_r == sgtp_pkg::KIND_GRID);
  assign slot_ok = !out_valid_r || res_ready;
  assign scr_w   = {cfg.screen_width, {FB{1'b0}}};
  assign scr_h   = {cfg.screen_height, {FB{1'b0}}};
  assign margin  = {cfg.gap, {FB{1'b0}}};
  assign org_x   = {cfg.origin_x[sgtp_pkg::ORG_W-1], cfg.origin_x, {FB{1'b0}}};
  assign org_y   = {cfg.origin_y[sgtp_pkg::ORG_W-1], cfg.origin_y, {FB{1'b0}}};

  // Grid footprint and the centering spans (both never negative).
  assign g_tw   = {{LW{1'b0}}, g_r} * {{GW{1'b0}}, tw_r};
  assign g_th   = {{LW{1'b0}}, g_r} * {{GW{1'b0}}, th_r};
  assign span_x = scr_w - (is_grid ? g_tw[LW-1:0] : tw_r);
  assign span_y = scr_h - (is_grid ? g_th[LW-1:0] : th_r);

  // Height limit: three quarters of the width.
  assign tw3    = {1'b0, tw_r} + {tw_r, 1'b0};
  assign th_lim = {1'b0, tw3[LW:2]};

  // Cell offsets; only cells on the grid (0..7) are ever emitted.
  assign x_tw = {{LW{1'b0}}, x_r[2:0]} * {3'b000, tw_r};
  assign y_th = {{LW{1'b0}}, y_r[2:0]} * {3'b000, th_r};

  assign in_grid = !x_r[CW-1] && (x_r[CW-2:0] < {1'b0, g_r})
                && !y_r[CW-1] && (y_r[CW-2:0] < {1'b0, g_r});
  assign is_last = ({1'b0, placed_r} + 1'b1) == count_r;

  assign passed_inc = sgtp_pkg::SEG_W'(passed_r + 1'b1);

  always_comb begin
    x_step = x_r;
    y_step = y_r;
    unique case (dir_r)
      sgtp_pkg::DIR_RIGHT: x_step = x_r + CW'(1);
      sgtp_pkg::DIR_DOWN:  y_step = y_r + CW'(1);
      sgtp_pkg::DIR_LEFT:  x_step = x_r - CW'(1);
      sgtp_pkg::DIR_UP:    y_step = y_r - CW'(1);
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    dir_nxt       = dir_r;
    count_nxt     = count_r;
    g_nxt         = g_r;
    tw_nxt        = tw_r;
    th_nxt        = th_r;
    base_x_nxt    = base_x_r;
    base_y_nxt    = base_y_r;
    size_w_nxt    = size_w_r;
    size_h_nxt    = size_h_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    seg_nxt       = seg_r;
    passed_nxt    = passed_r;
    turn_odd_nxt  = turn_odd_r;
    placed_nxt    = placed_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !res_ready;
    q_pop         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = is_grid ? {2'b00, scr_w} : {scr_w, 2'b00};
    div_req.divisor  = is_grid ? g_r : sgtp_pkg::SINGLE_DEN;

    unique case (state_r)
      sgtp_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop        = 1'b1;
          kind_nxt     = q_cmd.kind;
          count_nxt    = q_cmd.count;
          g_nxt        = q_cmd.side;
          x_nxt        = {3'b000, q_cmd.side[GW-1:1]};
          y_nxt        = {3'b000, q_cmd.side[GW-1:1]};
          dir_nxt      = sgtp_pkg::DIR_RIGHT;
          seg_nxt      = sgtp_pkg::SEG_W'(1);
          passed_nxt   = '0;
          turn_odd_nxt = 1'b0;
          placed_nxt   = '0;
          state_nxt    = (q_cmd.kind == sgtp_pkg::KIND_EMPTY)
                       ? sgtp_pkg::ST_EMIT_ONE : sgtp_pkg::ST_START_W;
        end
      end
      sgtp_pkg::ST_START_W: begin
        div_req.start = 1'b1;
        state_nxt     = sgtp_pkg::ST_WAIT_W;
      end
      sgtp_pkg::ST_WAIT_W: begin
        if (div_rsp.done) begin
          tw_nxt    = div_rsp.quotient[LW-1:0];
          state_nxt = sgtp_pkg::ST_START_H;
        end
      end
      sgtp_pkg::ST_START_H: begin
        div_req.start    = 1'b1;
        div_req.dividend = is_grid ? {2'b00, scr_h} : {scr_h, 2'b00};
        state_nxt        = sgtp_pkg::ST_WAIT_H;
      end
      sgtp_pkg::ST_WAIT_H: begin
        if (div_rsp.done) begin
          th_nxt    = div_rsp.quotient[LW-1:0];
          state_nxt = is_grid ? sgtp_pkg::ST_CLAMP : sgtp_pkg::ST_BASE;
        end
      end
      sgtp_pkg::ST_CLAMP: begin
        if (th_r > th_lim) begin
          th_nxt = th_lim;
        end
        state_nxt = sgtp_pkg::ST_BASE;
      end
      sgtp_pkg::ST_BASE: begin
        base_x_nxt = org_x + PW'({1'b0, span_x[LW-1:1]})
                   + (is_grid ? PW'(margin) : '0);
        base_y_nxt = org_y + PW'({1'b0, span_y[LW-1:1]})
                   + (is_grid ? PW'(margin) : '0);
        size_w_nxt = {1'b0, tw_r} - ZW'({margin, 1'b0});
        size_h_nxt = {1'b0, th_r} - ZW'({margin, 1'b0});
        state_nxt  = is_grid ? sgtp_pkg::ST_WALK : sgtp_pkg::ST_EMIT_ONE;
      end
      sgtp_pkg::ST_EMIT_ONE: begin
        if (slot_ok) begin
          out_valid_nxt      = 1'b1;
          res_nxt.last       = 1'b1;
          res_nxt.tile_index = '0;
          res_nxt.grid_side  = g_r;
          if (kind_r == sgtp_pkg::KIND_EMPTY) begin
            res_nxt.tile_valid = 1'b0;
            res_nxt.pos_x      = '0;
            res_nxt.pos_y      = '0;
            res_nxt.size_w     = '0;
            res_nxt.size_h     = '0;
          end else begin
            res_nxt.tile_valid = 1'b1;
            res_nxt.pos_x      = base_x_r;
            res_nxt.pos_y      = base_y_r;
            res_nxt.size_w     = size_w_r;
            res_nxt.size_h     = size_h_r;
          end
          state_nxt = sgtp_pkg::ST_IDLE;
        end
      end
      sgtp_pkg::ST_WALK: begin
        if (!in_grid || slot_ok) begin
          if (in_grid) begin
            out_valid_nxt      = 1'b1;
            res_nxt.last       = is_last;
            res_nxt.tile_valid = 1'b1;
            res_nxt.tile_index = placed_r;
            res_nxt.grid_side  = g_r;
            res_nxt.pos_x      = base_x_r + PW'(x_tw);
            res_nxt.pos_y      = base_y_r + PW'(y_th);
            res_nxt.size_w     = size_w_r;
            res_nxt.size_h     = size_h_r;
            placed_nxt         = sgtp_pkg::IDX_W'(placed_r + 1'b1);
            if (is_last) begin
              state_nxt = sgtp_pkg::ST_IDLE;
            end
          end
          // Move one cell; turn clockwise at the end of each segment.
          x_nxt = x_step;
          y_nxt = y_step;
          if (passed_inc == seg_r) begin
            passed_nxt   = '0;
            dir_nxt      = sgtp_pkg::dir_t'(dir_r + 1'b1);
            turn_odd_nxt = !turn_odd_r;
            if (turn_odd_r) begin
              seg_nxt = sgtp_pkg::SEG_W'(seg_r + 1'b1);
            end
          end else begin
            passed_nxt = passed_inc;
          end
        end
      end
      default: state_nxt = sgtp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    dir_r      <= dir_nxt;
    count_r    <= count_nxt;
    g_r        <= g_nxt;
    tw_r       <= tw_nxt;
    th_r       <= th_nxt;
    base_x_r   <= base_x_nxt;
    base_y_r   <= base_y_nxt;
    size_w_r   <= size_w_nxt;
    size_h_r   <= size_h_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    seg_r      <= seg_nxt;
    passed_r   <= passed_nxt;
    turn_odd_r <= turn_odd_nxt;
    placed_r   <= placed_nxt;
    res_r      <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sgtp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign res_valid = out_valid_r;
  assign res       = res_r;

endmodule

>>> sv/spiral_grid_tile_placer_top.sv
// ----------------------------------------------------------------------------
// spiral_grid_tile_placer_top
// Places up to 64 tile rectangles on a screen along a square spiral.
// ----------------------------------------------------------------------------
// Each input transaction carries a tile count and yields one output
// transaction per tile, or a single transaction with tile_valid low for a
// count of zero; tlast marks the final one. A non-empty request first makes
// two passes (width, then height) through the shared radix-2 divider. A grid
// request then clamps the height and walks the spiral one cell per cycle, on
// the grid or skipped, waiting on a grid cell while the output register is
// still full. A two-entry command queue lets new requests be taken while
// one is being placed, and an output register holds each result until the
// sink takes it. All lengths are in sixteenths of a pixel and truncate.
// ----------------------------------------------------------------------------
module spiral_grid_tile_placer_top (
  input  logic        clk,
  input  logic        rst_n,

  // Request stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [6:0] tile_count, [7] zero fill

  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  // [5:0] tile_index, [26:6] pos_x, [47:27] pos_y, [65:48] size_w,
  // [83:66] size_h, [87:84] grid_side
  output logic [87:0] out_tdata,
  output logic        out_tuser,   // [0] tile_valid
  output logic        out_tlast,

  // Register port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  sgtp_pkg::cfg_t     cfg_r, cfg_nxt;
  sgtp_pkg::cmd_t     push_cmd;
  sgtp_pkg::cmd_t     pop_cmd;
  sgtp_pkg::div_req_t div_req;
  sgtp_pkg::div_rsp_t div_rsp;
  sgtp_pkg::res_t     res;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  logic               cfg_wr;
  sgtp_pkg::cfg_reg_t cfg_sel;

  // Registers are taken in the access phase; there are no wait states.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = sgtp_pkg::cfg_reg_t'(cfg_paddr[4:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_sel)
        sgtp_pkg::REG_SCREEN_W: cfg_nxt.screen_width  = cfg_pwdata[sgtp_pkg::SCR_W-1:0];
        sgtp_pkg::REG_SCREEN_H: cfg_nxt.screen_height = cfg_pwdata[sgtp_pkg::SCR_W-1:0];
        sgtp_pkg::REG_ORIGIN_X: cfg_nxt.origin_x      = cfg_pwdata[sgtp_pkg::ORG_W-1:0];
        sgtp_pkg::REG_ORIGIN_Y: cfg_nxt.origin_y      = cfg_pwdata[sgtp_pkg::ORG_W-1:0];
        sgtp_pkg::REG_GAP:      cfg_nxt.gap           = cfg_pwdata[sgtp_pkg::GAP_W-1:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      sgtp_pkg::REG_SCREEN_W: cfg_prdata = sgtp_pkg::CFG_DW'(cfg_r.screen_width);
      sgtp_pkg::REG_SCREEN_H: cfg_prdata = sgtp_pkg::CFG_DW'(cfg_r.screen_height);
      sgtp_pkg::REG_ORIGIN_X: cfg_prdata = sgtp_pkg::CFG_DW'(cfg_r.origin_x);
      sgtp_pkg::REG_ORIGIN_Y: cfg_prdata = sgtp_pkg::CFG_DW'(cfg_r.origin_y);
      sgtp_pkg::REG_GAP:      cfg_prdata = sgtp_pkg::CFG_DW'(cfg_r.gap);
      default:                cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width  <= sgtp_pkg::RST_SCREEN_W;
      cfg_r.screen_height <= sgtp_pkg::RST_SCREEN_H;
      cfg_r.origin_x      <= '0;
      cfg_r.origin_y      <= '0;
      cfg_r.gap           <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front classifies each request and queues it as a command.
  sgtp_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  sgtp_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  // Shared divider for the tile width and height.
  sgtp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // The back sizes the tiles and walks the spiral, one cell per cycle unless a grid cell waits for the output register.
  sgtp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {res.grid_side, res.size_h, res.size_w,
                      res.pos_y, res.pos_x, res.tile_index};
  assign out_tuser = res.tile_valid;
  assign out_tlast = res.last;

endmodule
